// ===== sv/atsc_pkg.sv =====
// Shared types and constants for the adaptive tile-size controller.
// Holds the transaction payload structs, op and decision codes, register indexes
// and the sequencer state type. Depends on nothing.
package atsc_pkg;

  // Tile sizes and Q1.15 ratios.
  typedef logic [8:0]  size_t;
  typedef logic [15:0] q15_t;
  typedef logic [23:0] load_t;

  // Operation codes of an input transaction.
  typedef logic [2:0] op_t;
  localparam op_t OP_STATS   = 3'd0;
  localparam op_t OP_REQUEST = 3'd1;
  localparam op_t OP_APPLIED = 3'd2;
  localparam op_t OP_ALLOC   = 3'd3;
  localparam op_t OP_RESTART = 3'd4;

  // Decision codes of a result transaction.
  typedef logic [1:0] dec_t;
  localparam dec_t DEC_HOLD     = 2'd0;
  localparam dec_t DEC_REDUCED  = 2'd1;
  localparam dec_t DEC_INCREASED = 2'd2;

  // Configuration register indexes.
  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_ADAPT_ENABLE = 3'd0;
  localparam reg_idx_t REG_MIN_TILE     = 3'd1;
  localparam reg_idx_t REG_MAX_TILE     = 3'd2;
  localparam reg_idx_t REG_TILE_STEP    = 3'd3;
  localparam reg_idx_t REG_HOLDOFF      = 3'd4;
  localparam reg_idx_t REG_OCC_TARGETS  = 3'd5;
  localparam reg_idx_t REG_REDUCE_THR   = 3'd6;
  localparam reg_idx_t REG_SMOOTH_CAP   = 3'd7;

  localparam int CFG_DATA_W = 48;

  // Operand widths of the shared multiplier: a signed 25-bit difference or
  // capacity against a signed 17-bit smoothing factor or ratio.
  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Q1.15 constants.
  localparam logic [16:0] Q15_ONE   = 17'd32768;
  localparam int          Q15_FRAC  = 15;

  // Input transaction payload.
  typedef struct packed {
    op_t         op;
    size_t       requested_size;
    logic [13:0] view_width;
    logic [13:0] view_height;
    size_t       active_size;
    logic        size_changed;
    q15_t        occupancy;
    q15_t        dense_frac;
    q15_t        spill_frac;
    load_t       average_load;
    logic        tiles_present;
  } atsc_in_t;

  // Result transaction payload.
  typedef struct packed {
    size_t chosen_size;
    dec_t  decision;
    logic  metrics_ready;
  } atsc_out_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_STAT_MUL,
    ST_STAT_ACC,
    ST_DECIDE,
    ST_PUSH
  } state_t;

endpackage

// ===== sv/atsc_mul.sv =====
// Shared signed multiplier of the adaptive tile-size controller.
// One registered product per cycle; depends on atsc_pkg for operand widths.
module atsc_mul (
  input  logic                                    clk,
  input  logic signed [atsc_pkg::MUL_A_W-1:0]     a,
  input  logic signed [atsc_pkg::MUL_B_W-1:0]     b,
  output logic signed [atsc_pkg::MUL_P_W-1:0]     prod_r
);

  logic signed [atsc_pkg::MUL_P_W-1:0] prod_nxt;

  // Full-width signed product.
  assign prod_nxt = atsc_pkg::MUL_P_W'(a) * atsc_pkg::MUL_P_W'(b);

  // The product is registered before anything uses it.
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// ===== sv/adaptive_tile_size_controller.sv =====
// Adaptive tile-size controller top level: configuration registers, sequencer,
// moving averages and size decision. Depends on atsc_pkg and atsc_mul.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid / in_stall  atsc_pkg::atsc_in_t
//   out_     output     out_valid/out_stall  atsc_pkg::atsc_out_t
//   cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A frame-statistics transaction passes dispatch, multiply and accumulate states
// for each of the four moving averages (which share one multiplier), then push.
// A size request passes dispatch, decide (one product of ratio and capacity),
// and push, other ops dispatch and push. in_stall drops the cycle after loading.
// A waiting result lets one more transaction in, which then holds in_stall high
// until the output register drains. Reset (rst_n low, synchronous) clears state.
module adaptive_tile_size_controller #(
  parameter int DEFAULT_SIZE = 16,
  parameter int SIZE_LIMIT   = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  atsc_pkg::atsc_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output atsc_pkg::atsc_out_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  atsc_pkg::reg_idx_t                cfg_index,
  input  logic [atsc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // Sizes live in 9 bits, so a limit above that range never bites.
  localparam int                  LIM_CLIP = (SIZE_LIMIT > 511) ? 511 : SIZE_LIMIT;
  localparam atsc_pkg::size_t     LIMIT_SZ = 9'(LIM_CLIP);
  localparam atsc_pkg::size_t     DEF_SZ   = 9'(DEFAULT_SIZE);

  // Configuration registers.
  logic              adapt_enable_r;
  atsc_pkg::size_t   min_tile_r, max_tile_r, tile_step_r;
  logic [15:0]       holdoff_r;
  logic [31:0]       occ_targets_r;
  logic [47:0]       reduce_thr_r;
  logic [39:0]       smooth_cap_r;

  // Controller state.
  atsc_pkg::q15_t    avg_occ_r, avg_occ_nxt;
  atsc_pkg::q15_t    avg_dense_r, avg_dense_nxt;
  atsc_pkg::q15_t    avg_ovf_r, avg_ovf_nxt;
  atsc_pkg::load_t   avg_load_r, avg_load_nxt;
  logic [31:0]       fsc_r, fsc_nxt;
  logic              mv_r, mv_nxt;
  atsc_pkg::size_t   last_size_r, last_size_nxt;

  // Sequencer and work registers.
  atsc_pkg::state_t    state_r, state_nxt;
  atsc_pkg::atsc_in_t  in_r;
  logic [1:0]          idx_r, idx_nxt;
  atsc_pkg::size_t     req_size_r, req_size_nxt;
  atsc_pkg::size_t     cur_r, cur_nxt;
  logic                skip_r, skip_nxt;
  atsc_pkg::atsc_out_t res_r, res_nxt;
  atsc_pkg::atsc_out_t out_r;
  logic                out_valid_r, out_valid_nxt;
  logic                out_load;

  // Shared multiplier.
  logic signed [atsc_pkg::MUL_A_W-1:0] mul_a;
  logic signed [atsc_pkg::MUL_B_W-1:0] mul_b;
  logic signed [atsc_pkg::MUL_P_W-1:0] prod_r;

  // Effective configuration values.
  atsc_pkg::size_t   eff_min, eff_max, eff_step, min_lo;
  logic [15:0]       eff_hold;
  logic [16:0]       smooth_s;
  logic              smooth_zero;
  atsc_pkg::load_t   cap;
  atsc_pkg::q15_t    tgt, hys, thr_ovf, thr_dense, thr_avg;

  // Request cleaning.
  atsc_pkg::size_t   r_base, r_view, r_clamp, cur_base, cur_clamp;
  logic [13:0]       view_min, view_lim;

  // Smoothing datapath.
  atsc_pkg::load_t   raw_sel, avg_sel, smooth_val;
  logic signed [atsc_pkg::MUL_P_W-1:0] rounded, shifted, blended;

  // Decision datapath.
  logic [16:0]       occ_lower, occ_upper, hys_sum;
  logic              reduce, increase;
  logic [38:0]       load_scaled;
  logic [9:0]        up_sum;
  atsc_pkg::size_t   up_size, down_size, stepped_size;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != atsc_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Effective bounds, step, hold-off and unpacked register fields.
  always_comb begin
    min_lo      = (min_tile_r == '0) ? 9'd1 : min_tile_r;
    eff_min     = (min_lo > LIMIT_SZ) ? LIMIT_SZ : min_lo;
    eff_max     = (max_tile_r > eff_min) ? max_tile_r : eff_min;
    eff_max     = (eff_max > LIMIT_SZ) ? LIMIT_SZ : eff_max;
    eff_step    = (tile_step_r == '0) ? 9'd1 : tile_step_r;
    eff_hold    = (holdoff_r == '0) ? 16'd1 : holdoff_r;
    tgt         = occ_targets_r[31:16];
    hys         = occ_targets_r[15:0];
    thr_ovf     = reduce_thr_r[47:32];
    thr_dense   = reduce_thr_r[31:16];
    thr_avg     = reduce_thr_r[15:0];
    smooth_s    = (smooth_cap_r[39:24] > atsc_pkg::Q15_ONE[15:0] &&
                   smooth_cap_r[39:24] != 16'h8000) ? atsc_pkg::Q15_ONE
                  : {1'b0, smooth_cap_r[39:24]};
    smooth_zero = (smooth_cap_r[39:24] == '0);
    cap         = (smooth_cap_r[23:0] == '0) ? 24'd1 : smooth_cap_r[23:0];
  end

  // Request cleaning: fallback, viewport limit and clamp to the bounds.
  always_comb begin
    if (in_r.requested_size != '0) begin
      r_base = in_r.requested_size;
    end else if (in_r.active_size != '0) begin
      r_base = in_r.active_size;
    end else begin
      r_base = DEF_SZ;
    end
    view_min = (in_r.view_width < in_r.view_height) ? in_r.view_width : in_r.view_height;
    view_lim = (view_min == '0) ? 14'd1 : view_min;
    r_view   = r_base;
    if (in_r.view_width != '0 && in_r.view_height != '0 && {5'b0, r_base} > view_lim) begin
      r_view = view_lim[8:0];
    end
    r_clamp   = (r_view < eff_min) ? eff_min : r_view;
    r_clamp   = (r_clamp > eff_max) ? eff_max : r_clamp;
    cur_base  = (in_r.active_size != '0) ? in_r.active_size : r_clamp;
    cur_clamp = (cur_base < eff_min) ? eff_min : cur_base;
    cur_clamp = (cur_clamp > eff_max) ? eff_max : cur_clamp;
  end

  // Metric selection and blend: avg + round((raw - avg) * S / 32768).
  always_comb begin
    unique case (idx_r)
      2'd0: begin
        raw_sel = {8'b0, in_r.occupancy};
        avg_sel = {8'b0, avg_occ_r};
      end
      2'd1: begin
        raw_sel = {8'b0, in_r.dense_frac};
        avg_sel = {8'b0, avg_dense_r};
      end
      2'd2: begin
        raw_sel = {8'b0, in_r.spill_frac};
        avg_sel = {8'b0, avg_ovf_r};
      end
      default: begin
        raw_sel = in_r.average_load;
        avg_sel = avg_load_r;
      end
    endcase
    rounded    = prod_r + atsc_pkg::MUL_P_W'(16384);
    shifted    = rounded >>> atsc_pkg::Q15_FRAC;
    blended    = shifted + $signed({{(atsc_pkg::MUL_P_W-24){1'b0}}, avg_sel});
    smooth_val = (!mv_r || smooth_zero) ? raw_sel : blended[23:0];
  end

  // Multiplier operands: metric difference by S, or capacity by average ratio.
  always_comb begin
    if (state_r == atsc_pkg::ST_STAT_MUL) begin
      mul_a = $signed({1'b0, raw_sel}) - $signed({1'b0, avg_sel});
      mul_b = $signed(smooth_s);
    end else begin
      mul_a = $signed({1'b0, cap});
      mul_b = $signed({1'b0, thr_avg});
    end
  end

  atsc_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  // Reduce and increase tests and the stepped size.
  always_comb begin
    hys_sum     = {1'b0, tgt} + {1'b0, hys};
    occ_lower   = (tgt > hys) ? {1'b0, tgt - hys} : 17'd0;
    occ_upper   = (hys_sum > atsc_pkg::Q15_ONE) ? atsc_pkg::Q15_ONE : hys_sum;
    load_scaled = {avg_load_r, 15'b0};
    reduce      = (avg_ovf_r > thr_ovf) || (avg_dense_r > thr_dense) ||
                  ($signed({3'b0, load_scaled}) > prod_r);
    increase    = !reduce &&
                  (({1'b0, avg_occ_r} < occ_lower && {avg_ovf_r, 1'b0} < {1'b0, thr_ovf}) ||
                   ({1'b0, avg_occ_r} > occ_upper && {avg_dense_r, 1'b0} < {1'b0, thr_dense}));
    down_size   = ((cur_r - eff_min) > eff_step) ? (cur_r - eff_step) : eff_min;
    up_sum      = {1'b0, cur_r} + {1'b0, eff_step};
    up_size     = (up_sum > {1'b0, eff_max}) ? eff_max : up_sum[8:0];
    if (reduce && cur_r > eff_min) begin
      stepped_size = down_size;
    end else if (increase && cur_r < eff_max) begin
      stepped_size = up_size;
    end else begin
      stepped_size = cur_r;
    end
  end

  // Result register hand-off: load when the slot is empty or being drained.
  assign out_load = (state_r == atsc_pkg::ST_PUSH) && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Sequencer: next state and state updates.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    req_size_nxt  = req_size_r;
    cur_nxt       = cur_r;
    skip_nxt      = skip_r;
    res_nxt       = res_r;
    avg_occ_nxt   = avg_occ_r;
    avg_dense_nxt = avg_dense_r;
    avg_ovf_nxt   = avg_ovf_r;
    avg_load_nxt  = avg_load_r;
    fsc_nxt       = fsc_r;
    mv_nxt        = mv_r;
    last_size_nxt = last_size_r;

    unique case (state_r)
      atsc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = atsc_pkg::ST_DISPATCH;
        end
      end

      atsc_pkg::ST_DISPATCH: begin
        res_nxt.decision      = atsc_pkg::DEC_HOLD;
        res_nxt.chosen_size   = last_size_r;
        res_nxt.metrics_ready = mv_r;
        state_nxt             = atsc_pkg::ST_PUSH;
        unique case (in_r.op)
          atsc_pkg::OP_STATS: begin
            idx_nxt   = 2'd0;
            state_nxt = atsc_pkg::ST_STAT_MUL;
          end
          atsc_pkg::OP_REQUEST: begin
            req_size_nxt = r_clamp;
            cur_nxt      = cur_clamp;
            skip_nxt     = !adapt_enable_r || !mv_r || (fsc_r < {16'b0, eff_hold});
            state_nxt    = atsc_pkg::ST_DECIDE;
          end
          atsc_pkg::OP_APPLIED: begin
            last_size_nxt       = in_r.active_size;
            res_nxt.chosen_size = in_r.active_size;
            if (in_r.size_changed) begin
              fsc_nxt = '0;
            end
          end
          atsc_pkg::OP_ALLOC: begin
            last_size_nxt       = in_r.active_size;
            res_nxt.chosen_size = in_r.active_size;
            fsc_nxt             = {16'b0, eff_hold};
          end
          atsc_pkg::OP_RESTART: begin
            avg_occ_nxt           = '0;
            avg_dense_nxt         = '0;
            avg_ovf_nxt           = '0;
            avg_load_nxt          = '0;
            mv_nxt                = 1'b0;
            last_size_nxt         = in_r.active_size;
            res_nxt.chosen_size   = in_r.active_size;
            res_nxt.metrics_ready = 1'b0;
            fsc_nxt               = {16'b0, eff_hold};
          end
          default: begin
            // Unused op codes leave the state alone.
          end
        endcase
      end

      atsc_pkg::ST_STAT_MUL: begin
        state_nxt = atsc_pkg::ST_STAT_ACC;
      end

      atsc_pkg::ST_STAT_ACC: begin
        unique case (idx_r)
          2'd0:    avg_occ_nxt   = smooth_val[15:0];
          2'd1:    avg_dense_nxt = smooth_val[15:0];
          2'd2:    avg_ovf_nxt   = smooth_val[15:0];
          default: avg_load_nxt  = smooth_val;
        endcase
        if (idx_r == 2'd3) begin
          mv_nxt = in_r.tiles_present;
          if (in_r.tiles_present && fsc_r != '1) begin
            fsc_nxt = fsc_r + 32'd1;
          end
          res_nxt.metrics_ready = in_r.tiles_present;
          state_nxt             = atsc_pkg::ST_PUSH;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = atsc_pkg::ST_STAT_MUL;
        end
      end

      atsc_pkg::ST_DECIDE: begin
        if (skip_r) begin
          res_nxt.chosen_size = req_size_r;
          res_nxt.decision    = atsc_pkg::DEC_HOLD;
        end else begin
          res_nxt.chosen_size = stepped_size;
          if (stepped_size < cur_r) begin
            res_nxt.decision = atsc_pkg::DEC_REDUCED;
          end else if (stepped_size > cur_r) begin
            res_nxt.decision = atsc_pkg::DEC_INCREASED;
          end else begin
            res_nxt.decision = atsc_pkg::DEC_HOLD;
          end
        end
        state_nxt = atsc_pkg::ST_PUSH;
      end

      atsc_pkg::ST_PUSH: begin
        if (out_load) begin
          state_nxt = atsc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = atsc_pkg::ST_IDLE;
      end
    endcase
  end

  // Control and controller state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= atsc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      avg_occ_r   <= '0;
      avg_dense_r <= '0;
      avg_ovf_r   <= '0;
      avg_load_r  <= '0;
      fsc_r       <= '0;
      mv_r        <= 1'b0;
      last_size_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      avg_occ_r   <= avg_occ_nxt;
      avg_dense_r <= avg_dense_nxt;
      avg_ovf_r   <= avg_ovf_nxt;
      avg_load_r  <= avg_load_nxt;
      fsc_r       <= fsc_nxt;
      mv_r        <= mv_nxt;
      last_size_r <= last_size_nxt;
    end
  end

  // Payload and work registers.
  always_ff @(posedge clk) begin
    if (state_r == atsc_pkg::ST_IDLE && in_valid) begin
      in_r <= in_data;
    end
    if (out_load) begin
      out_r <= res_r;
    end
    idx_r      <= idx_nxt;
    req_size_r <= req_size_nxt;
    cur_r      <= cur_nxt;
    skip_r     <= skip_nxt;
    res_r      <= res_nxt;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adapt_enable_r <= 1'b0;
      min_tile_r     <= 9'd8;
      max_tile_r     <= 9'd64;
      tile_step_r    <= 9'd8;
      holdoff_r      <= 16'd4;
      occ_targets_r  <= '0;
      reduce_thr_r   <= '0;
      smooth_cap_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        atsc_pkg::REG_ADAPT_ENABLE: adapt_enable_r <= cfg_data[0];
        atsc_pkg::REG_MIN_TILE:     min_tile_r     <= cfg_data[8:0];
        atsc_pkg::REG_MAX_TILE:     max_tile_r     <= cfg_data[8:0];
        atsc_pkg::REG_TILE_STEP:    tile_step_r    <= cfg_data[8:0];
        atsc_pkg::REG_HOLDOFF:      holdoff_r      <= cfg_data[15:0];
        atsc_pkg::REG_OCC_TARGETS:  occ_targets_r  <= cfg_data[31:0];
        atsc_pkg::REG_REDUCE_THR:   reduce_thr_r   <= cfg_data[47:0];
        atsc_pkg::REG_SMOOTH_CAP:   smooth_cap_r   <= cfg_data[39:0];
      endcase
    end
  end

endmodule

// ===== verif/tile_size_monitor.sv =====
// Checker for the adaptive tile-size controller: watches the three channels,
// predicts every result transaction and compares it field by field.
// Depends on atsc_pkg.
module tile_size_monitor #(
  parameter int DEFAULT_SIZE = 16,
  parameter int SIZE_LIMIT   = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  atsc_pkg::atsc_in_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  atsc_pkg::atsc_out_t             out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  atsc_pkg::reg_idx_t              cfg_index,
  input  logic [atsc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              size_mismatches,
  output int                              sizes_owed
);

  // Shadow copy of the configuration registers.
  logic        en_adapt;
  logic [8:0]  lim_min;
  logic [8:0]  lim_max;
  logic [8:0]  step_size;
  logic [15:0] hold_frames;
  logic [31:0] occ_targets;
  logic [47:0] reduce_thr;
  logic [39:0] smooth_cap;

  // Predicted controller state.
  logic [15:0] ema_occ;
  logic [15:0] ema_dense;
  logic [15:0] ema_ovf;
  logic [23:0] ema_load;
  logic [31:0] frames_seen;
  logic        stats_ok;
  logic [8:0]  recorded_size;

  atsc_pkg::atsc_out_t predicted_sizes[$];
  int                  fail_count;

  function automatic int unsigned floor_size();
    int unsigned m;
    m = (lim_min == 0) ? 1 : lim_min;
    return (m > SIZE_LIMIT) ? SIZE_LIMIT : m;
  endfunction

  function automatic int unsigned ceil_size();
    int unsigned m;
    m = (lim_max > floor_size()) ? lim_max : floor_size();
    return (m > SIZE_LIMIT) ? SIZE_LIMIT : m;
  endfunction

  function automatic int unsigned holdoff_span();
    return (hold_frames == 0) ? 1 : hold_frames;
  endfunction

  function automatic int unsigned fit_size(int unsigned v);
    if (v < floor_size()) return floor_size();
    if (v > ceil_size()) return ceil_size();
    return v;
  endfunction

  // Exponential moving average in Q1.15 with round to nearest.
  function automatic int unsigned ema_blend(int unsigned avg, int unsigned raw,
                                            int unsigned s, logic had);
    longint unsigned acc;
    if (!had || s == 0) return raw;
    acc = 64'(avg) * 64'(32768 - s) + 64'(raw) * 64'(s) + 64'd16384;
    return 32'(acc >> 15);
  endfunction

  // Size request: clean the request, then step it down or up when allowed.
  function automatic int unsigned pick_size(atsc_pkg::atsc_in_t it,
                                            output atsc_pkg::dec_t dec);
    int unsigned r, side, mn, mx, stp, tgt, hys, ot, dt, ar, cap;
    int unsigned lower, upper, cur, nsz, occ, dns, ovf;
    longint unsigned load_lhs, load_rhs;
    logic shrink, grow;
    dec = atsc_pkg::DEC_HOLD;
    r = (it.requested_size != 0) ? it.requested_size :
        (it.active_size != 0) ? it.active_size : DEFAULT_SIZE;
    if (it.view_width != 0 && it.view_height != 0) begin
      side = (it.view_width < it.view_height) ? it.view_width : it.view_height;
      if (r > side) r = side;
    end
    r = fit_size(r);
    if (!en_adapt || !stats_ok || frames_seen < holdoff_span()) return r;

    mn = floor_size();
    mx = ceil_size();
    stp = (step_size == 0) ? 1 : step_size;
    cur = fit_size((it.active_size != 0) ? it.active_size : r);
    tgt = occ_targets[31:16];
    hys = occ_targets[15:0];
    lower = (tgt > hys) ? tgt - hys : 0;
    upper = (tgt + hys > 32768) ? 32768 : tgt + hys;
    ot = reduce_thr[47:32];
    dt = reduce_thr[31:16];
    ar = reduce_thr[15:0];
    cap = (smooth_cap[23:0] == 0) ? 1 : smooth_cap[23:0];
    occ = ema_occ;
    dns = ema_dense;
    ovf = ema_ovf;
    load_lhs = 64'(ema_load) * 64'd32768;
    load_rhs = 64'(ar) * 64'(cap);

    shrink = (ovf > ot) || (dns > dt) || (load_lhs > load_rhs);
    grow = 1'b0;
    if (!shrink)
      grow = (occ < lower && 2 * ovf < ot) || (occ > upper && 2 * dns < dt);

    nsz = cur;
    if (shrink && cur > mn) begin
      nsz = (cur - mn > stp) ? cur - stp : mn;
    end else if (grow && cur < mx) begin
      nsz = (cur + stp < mx) ? cur + stp : mx;
    end
    if (nsz < cur) dec = atsc_pkg::DEC_REDUCED;
    else if (nsz > cur) dec = atsc_pkg::DEC_INCREASED;
    return nsz;
  endfunction

  // Applies one input transaction to the predicted state and returns its result.
  function automatic atsc_pkg::atsc_out_t predict_tile_result(atsc_pkg::atsc_in_t it);
    atsc_pkg::atsc_out_t res;
    int unsigned         s, sz;
    atsc_pkg::dec_t      dec;
    logic                had;
    dec = atsc_pkg::DEC_HOLD;
    sz = 0;
    case (it.op)
      atsc_pkg::OP_STATS: begin
        had = stats_ok;
        s = smooth_cap[39:24];
        if (s > 32768) s = 32768;
        ema_occ = 16'(ema_blend(ema_occ, it.occupancy, s, had));
        ema_dense = 16'(ema_blend(ema_dense, it.dense_frac, s, had));
        ema_ovf = 16'(ema_blend(ema_ovf, it.spill_frac, s, had));
        ema_load = 24'(ema_blend(ema_load, it.average_load, s, had));
        stats_ok = it.tiles_present;
        if (stats_ok && frames_seen != 32'hFFFF_FFFF) frames_seen = frames_seen + 1;
      end
      atsc_pkg::OP_REQUEST: sz = pick_size(it, dec);
      atsc_pkg::OP_APPLIED: begin
        recorded_size = it.active_size;
        if (it.size_changed) frames_seen = '0;
      end
      atsc_pkg::OP_ALLOC: begin
        recorded_size = it.active_size;
        frames_seen = holdoff_span();
      end
      atsc_pkg::OP_RESTART: begin
        ema_occ = '0;
        ema_dense = '0;
        ema_ovf = '0;
        ema_load = '0;
        stats_ok = 1'b0;
        recorded_size = it.active_size;
        frames_seen = holdoff_span();
      end
      default: ;
    endcase
    if (it.op != atsc_pkg::OP_REQUEST) sz = recorded_size;
    res.chosen_size = sz[8:0];
    res.decision = dec;
    res.metrics_ready = stats_ok;
    return res;
  endfunction

  // Tracks every accepted transaction; results are checked before inputs are
  // predicted so a result can never match an item taken at the same edge.
  always @(posedge clk) begin
    atsc_pkg::atsc_out_t want;
    atsc_pkg::atsc_out_t got;
    if (!rst_n) begin
      en_adapt = 1'b0;
      lim_min = 9'd8;
      lim_max = 9'd64;
      step_size = 9'd8;
      hold_frames = 16'd4;
      occ_targets = '0;
      reduce_thr = '0;
      smooth_cap = '0;
      ema_occ = '0;
      ema_dense = '0;
      ema_ovf = '0;
      ema_load = '0;
      frames_seen = '0;
      stats_ok = 1'b0;
      recorded_size = '0;
      predicted_sizes.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          atsc_pkg::REG_ADAPT_ENABLE: en_adapt = cfg_data[0];
          atsc_pkg::REG_MIN_TILE:     lim_min = cfg_data[8:0];
          atsc_pkg::REG_MAX_TILE:     lim_max = cfg_data[8:0];
          atsc_pkg::REG_TILE_STEP:    step_size = cfg_data[8:0];
          atsc_pkg::REG_HOLDOFF:      hold_frames = cfg_data[15:0];
          atsc_pkg::REG_OCC_TARGETS:  occ_targets = cfg_data[31:0];
          atsc_pkg::REG_REDUCE_THR:   reduce_thr = cfg_data[47:0];
          atsc_pkg::REG_SMOOTH_CAP:   smooth_cap = cfg_data[39:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        if (predicted_sizes.size() == 0) begin
          $error("unexpected result transaction: chosen_size %0d", got.chosen_size);
          fail_count++;
        end else begin
          want = predicted_sizes.pop_front();
          if (got.chosen_size !== want.chosen_size) begin
            $error("chosen_size: expected %0d, got %0d", want.chosen_size,
                   got.chosen_size);
            fail_count++;
          end
          if (got.decision !== want.decision) begin
            $error("decision: expected %0d, got %0d", want.decision, got.decision);
            fail_count++;
          end
          if (got.metrics_ready !== want.metrics_ready) begin
            $error("metrics_ready: expected %0d, got %0d",
                   want.metrics_ready, got.metrics_ready);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) predicted_sizes.push_back(predict_tile_result(in_data));
    end
    size_mismatches <= fail_count;
    sizes_owed <= predicted_sizes.size();
  end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the adaptive tile-size controller: clock, reset, stimulus,
// receiver stalls and the verdict. Depends on atsc_pkg, the controller RTL and
// tile_size_monitor, which predicts and checks every result transaction.
module tb_top;

  localparam int             WATCHDOG_LIMIT = 4000;
  localparam int             RX_HOLD_CYCLES = 300;
  localparam int             DRAIN_CYCLES   = 16;
  localparam int             BLOCK_ITEMS    = 150;
  localparam atsc_pkg::op_t  OP_UNUSED_LO   = 3'd5;
  localparam atsc_pkg::op_t  OP_UNUSED_HI   = 3'd7;

  typedef enum {SET_TYPICAL, SET_ZERO, SET_FULL, SET_RAW, SET_DIRECTED} settings_kind_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  atsc_pkg::atsc_in_t              in_data = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  atsc_pkg::atsc_out_t             out_data;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  atsc_pkg::reg_idx_t              cfg_index = atsc_pkg::REG_ADAPT_ENABLE;
  logic [atsc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int          mismatch_total;
  int          owed_total;
  int          items_sent = 0;
  int unsigned tx_gap_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned load_span = 1;
  logic        rx_hold_req = 1'b0;
  int          rx_hold_count;
  int          quiet_cycles;
  logic        moved;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  adaptive_tile_size_controller dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tile_size_monitor size_mon (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .size_mismatches(mismatch_total), .sizes_owed(owed_total)
  );

  // Receiver: one long hold-off when requested, otherwise random stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_hold_count <= 0;
    end else if (rx_hold_req && rx_hold_count < RX_HOLD_CYCLES) begin
      out_stall <= 1'b1;
      rx_hold_count <= rx_hold_count + 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Watchdog on cycles in which no transaction moves on any channel.
  assign moved = (in_valid && !in_stall) || (out_valid && !out_stall) ||
                 (cfg_valid && cfg_ready);

  always @(posedge clk) begin
    if (!rst_n || moved) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Random field values, weighted toward the interesting ranges.
  function automatic atsc_pkg::atsc_in_t noise_item();
    logic [127:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom};
    return bits[$bits(atsc_pkg::atsc_in_t)-1:0];
  endfunction

  function automatic logic [8:0] rand_size();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 15) return '0;
    if (pick < 20) return 9'($urandom);
    return 9'($urandom_range(1, 256));
  endfunction

  function automatic logic [13:0] rand_view();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 15) return '0;
    if (pick < 25) return 14'($urandom);
    return 14'($urandom_range(1, 300));
  endfunction

  function automatic logic [15:0] rand_ratio();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return 16'($urandom);
    if (pick < 15) return '0;
    if (pick < 20) return 16'd32768;
    return 16'($urandom_range(0, 32768));
  endfunction

  function automatic logic [15:0] rand_ovf();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) return 16'($urandom_range(0, 8192));
    if (pick < 90) return 16'($urandom_range(0, 32768));
    return 16'($urandom);
  endfunction

  function automatic logic [23:0] rand_load();
    if ($urandom_range(9) == 0) return 24'($urandom);
    return 24'($urandom_range(0, load_span));
  endfunction

  // Transaction builders; fields the op ignores keep random values.
  function automatic atsc_pkg::atsc_in_t frame_stats(logic [15:0] occ, logic [15:0] dns,
                                                     logic [15:0] ovf, logic [23:0] load,
                                                     logic tiles);
    atsc_pkg::atsc_in_t it;
    it = noise_item();
    it.op = atsc_pkg::OP_STATS;
    it.occupancy = occ;
    it.dense_frac = dns;
    it.spill_frac = ovf;
    it.average_load = load;
    it.tiles_present = tiles;
    return it;
  endfunction

  function automatic atsc_pkg::atsc_in_t size_req(logic [8:0] req, logic [8:0] cs,
                                                  logic [13:0] w, logic [13:0] h);
    atsc_pkg::atsc_in_t it;
    it = noise_item();
    it.op = atsc_pkg::OP_REQUEST;
    it.requested_size = req;
    it.active_size = cs;
    it.view_width = w;
    it.view_height = h;
    return it;
  endfunction

  function automatic atsc_pkg::atsc_in_t size_event(atsc_pkg::op_t op, logic [8:0] cs,
                                                    logic changed);
    atsc_pkg::atsc_in_t it;
    it = noise_item();
    it.op = op;
    it.active_size = cs;
    it.size_changed = changed;
    return it;
  endfunction

  // Offers one input transaction after a random gap and waits for acceptance.
  task automatic send(atsc_pkg::atsc_in_t item);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Stops offering and waits until every predicted result has arrived.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (owed_total != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high so back-to-back writes need no second assignment.
  task automatic write_reg(atsc_pkg::reg_idx_t idx,
                           logic [atsc_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Writes all eight registers with one family of settings.
  task automatic program_settings(settings_kind_t kind);
    logic [atsc_pkg::CFG_DATA_W-1:0] v [8];
    int unsigned mn;
    int unsigned cap;
    case (kind)
      SET_ZERO: begin
        foreach (v[i]) v[i] = '0;
        v[atsc_pkg::REG_ADAPT_ENABLE] = 48'd1;
      end
      SET_FULL: foreach (v[i]) v[i] = '1;
      SET_RAW:  foreach (v[i]) v[i] = 48'({$urandom, $urandom});
      SET_DIRECTED: begin
        v[atsc_pkg::REG_ADAPT_ENABLE] = 48'd1;
        v[atsc_pkg::REG_MIN_TILE] = 48'd8;
        v[atsc_pkg::REG_MAX_TILE] = 48'd64;
        v[atsc_pkg::REG_TILE_STEP] = 48'd8;
        v[atsc_pkg::REG_HOLDOFF] = 48'd1;
        v[atsc_pkg::REG_OCC_TARGETS] = {16'd0, 16'd16384, 16'd4096};
        v[atsc_pkg::REG_REDUCE_THR] = {16'd8192, 16'd16384, 16'd16384};
        v[atsc_pkg::REG_SMOOTH_CAP] = {8'd0, 16'd0, 24'd100};
      end
      default: begin
        mn = $urandom_range(1, 48);
        v[atsc_pkg::REG_ADAPT_ENABLE] = 48'($urandom_range(7) != 0);
        v[atsc_pkg::REG_MIN_TILE] = 48'(mn);
        v[atsc_pkg::REG_MAX_TILE] = 48'($urandom_range(mn, 256));
        v[atsc_pkg::REG_TILE_STEP] = 48'($urandom_range(1, 24));
        v[atsc_pkg::REG_HOLDOFF] = 48'($urandom_range(1, 3));
        v[atsc_pkg::REG_OCC_TARGETS] = {16'd0, 16'($urandom_range(4096, 28672)),
                                        16'($urandom_range(0, 8192))};
        v[atsc_pkg::REG_REDUCE_THR] = {16'($urandom_range(0, 32768)),
                                       16'($urandom_range(0, 32768)),
                                       16'($urandom_range(0, 32768))};
        v[atsc_pkg::REG_SMOOTH_CAP] = {8'd0, 16'($urandom_range(0, 32768)),
                                       24'($urandom_range(1, 4096))};
      end
    endcase
    for (int i = 0; i < 8; i++) write_reg(atsc_pkg::reg_idx_t'(i), v[i]);
    cfg_valid <= 1'b0;
    cap = v[atsc_pkg::REG_SMOOTH_CAP][23:0];
    load_span = (cap == 0) ? 1 : cap;
  endtask

  // Mostly well-formed frames: statistics, requests, then the size outcome.
  task automatic random_burst(int n);
    int          stop_at;
    int unsigned pick;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send(noise_item());
      end else begin
        send(frame_stats(rand_ratio(), rand_ratio(), rand_ovf(), rand_load(),
                         $urandom_range(9) != 0));
        repeat ($urandom_range(1, 2))
          send(size_req(rand_size(), rand_size(), rand_view(), rand_view()));
        pick = $urandom_range(9);
        if (pick < 4) begin
          send(size_event(atsc_pkg::OP_APPLIED, rand_size(), $urandom_range(1)));
        end else if (pick == 4) begin
          send(size_event(atsc_pkg::OP_ALLOC, rand_size(), 1'b0));
        end else if (pick == 5) begin
          send(size_event(atsc_pkg::OP_RESTART, rand_size(), 1'b0));
        end
      end
    end
  endtask

  initial begin
    settings_kind_t plan [9];
    plan = '{SET_TYPICAL, SET_ZERO, SET_TYPICAL, SET_RAW, SET_FULL,
             SET_TYPICAL, SET_TYPICAL, SET_TYPICAL, SET_RAW};
    tx_gap_pct = 9;
    rx_stall_pct = 70;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: default size, viewport limits, clamping and every op.
    send(size_req(0, 0, 0, 0));
    send(size_req(256, 0, 14'h3FFF, 14'h3FFF));
    send(size_req(0, 200, 5, 100));
    send(size_req(9'h1FF, 9'h1FF, 0, 300));
    send(frame_stats(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 1'b0));
    send(size_event(atsc_pkg::OP_APPLIED, 256, 1'b1));
    send(size_event(atsc_pkg::OP_ALLOC, 0, 1'b0));
    send(size_event(OP_UNUSED_LO, 33, 1'b1));
    send(size_event(OP_UNUSED_HI, 9'h1FF, 1'b0));
    send(size_event(atsc_pkg::OP_RESTART, 9'h1FF, 1'b0));
    settle();

    // Adaptation: reduce on overflow and load, hold at the bounds, increase
    // below and above the occupancy band, and the hold-off after a change.
    program_settings(SET_DIRECTED);
    send(frame_stats(16384, 0, 0, 10, 1'b1));
    send(size_req(32, 32, 0, 0));
    send(frame_stats(16384, 0, 20000, 10, 1'b1));
    send(size_req(32, 32, 0, 0));
    send(frame_stats(16384, 0, 0, 60, 1'b1));
    send(size_req(8, 8, 0, 0));
    send(frame_stats(1000, 0, 0, 0, 1'b1));
    send(size_req(0, 64, 0, 0));
    send(size_req(0, 32, 0, 0));
    send(frame_stats(30000, 0, 0, 0, 1'b1));
    send(size_req(20, 0, 0, 0));
    send(size_event(atsc_pkg::OP_APPLIED, 28, 1'b1));
    send(size_req(20, 28, 0, 0));
    send(size_event(atsc_pkg::OP_ALLOC, 28, 1'b0));
    send(size_req(20, 28, 0, 0));
    settle();

    // Random blocks, each under its own settings and idling pattern.
    for (int blk = 0; blk < 9; blk++) begin
      if (blk < 3) begin
        tx_gap_pct = 9;
        rx_stall_pct = 70;
      end else if (blk < 6) begin
        tx_gap_pct = 70;
        rx_stall_pct = 9;
      end else begin
        tx_gap_pct = 0;
        rx_stall_pct = 0;
      end
      if (blk == 6) rx_hold_req = 1'b1;
      program_settings(plan[blk]);
      random_burst(BLOCK_ITEMS);
      settle();
    end

    if (mismatch_total == 0 && owed_total == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
